>>> rtl/core/fractal_image_decode_iteration_core_assert.svh
// assertion macros for the fractal decode core
`ifndef FRACTAL_IMAGE_DECODE_ITERATION_CORE_ASSERT_SVH
`define FRACTAL_IMAGE_DECODE_ITERATION_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FIDI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fidi assertion failed");
// next-cycle implication
`define FIDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fidi assertion failed");
`else
`define FIDI_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FIDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/fidi_pkg.sv
// shared types, codes and helpers of the fractal decode core
package fidi_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE_PIX = 2'd0,
        CMD_WRITE_MAP = 2'd1,
        CMD_RUN       = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OR_ROT0      = 3'd0,
        OR_ROT90     = 3'd1,
        OR_ROT180    = 3'd2,
        OR_ROT270    = 3'd3,
        OR_MIR_ROT0  = 3'd4,
        OR_MIR_ROT90 = 3'd5,
        OR_MIR_ROT180 = 3'd6,
        OR_MIR_ROT270 = 3'd7
    } orient_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN_INIT,
        ST_BLOCK,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_FETCH3,
        ST_ACC,
        ST_MUL,
        ST_STORE,
        ST_DONE
    } state_t;

    localparam int OFS_W = 5;
    localparam logic [2:0] LG_MIN = 3'd1;
    localparam logic [2:0] LG_MAX = 3'd5;

    typedef struct packed {
        logic [2:0]         orientation;
        logic signed [15:0] bias;
        logic signed [15:0] scale;
        logic [7:0]         domain_y;
        logic [7:0]         domain_x;
    } map_entry_t;

    typedef struct packed {
        logic       accept;
        logic       run_init;
        logic       map_rd;
        logic       fetch;
        logic [1:0] fetch_k;
        logic       mul;
        logic       store;
        logic       step_pix;
        logic       step_blk;
        logic       load_read;
        logic       load_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic blk_ok;
        logic pix_last;
        logic blk_last;
    } dp_stat_t;

    // top-left cell offset {row, col} in cell units for a range pixel
    function automatic logic [2*OFS_W-1:0] cell_offset(
        input logic [2:0]       orient,
        input logic [OFS_W-1:0] r,
        input logic [OFS_W-1:0] c,
        input logic [OFS_W-1:0] rr
    );
        logic [OFS_W-1:0] oy;
        logic [OFS_W-1:0] ox;
        case (orient_t'(orient))
            OR_ROT0:       begin oy = r;      ox = c;      end
            OR_ROT90:      begin oy = c;      ox = rr - r; end
            OR_ROT180:     begin oy = rr - r; ox = rr - c; end
            OR_ROT270:     begin oy = rr - c; ox = r;      end
            OR_MIR_ROT0:   begin oy = r;      ox = rr - c; end
            OR_MIR_ROT90:  begin oy = rr - c; ox = rr - r; end
            OR_MIR_ROT180: begin oy = rr - r; ox = c;      end
            default:       begin oy = c;      ox = r;      end
        endcase
        return {oy, ox};
    endfunction

endpackage

>>> rtl/core/fidi_ram.sv
// generic single-write, single-read ram with registered read data
module fidi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fidi_ctrl.sv
// command sequencer of the fractal decode core
module fidi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           cmd,
    input  fidi_pkg::dp_stat_t   stat,
    output logic                 in_stall,
    output fidi_pkg::ctrl_cmd_t  ctl
);

    fidi_pkg::state_t state_reg;
    fidi_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fidi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            fidi_pkg::ST_IDLE:
            begin
                in_stall = !stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    ctl.accept = 1'b1;
                    case (fidi_pkg::cmd_t'(cmd))
                        fidi_pkg::CMD_READ: state_next = fidi_pkg::ST_READ;
                        fidi_pkg::CMD_RUN:  state_next = fidi_pkg::ST_RUN_INIT;
                        default:            state_next = fidi_pkg::ST_IDLE;
                    endcase
                end
            end
            fidi_pkg::ST_READ:
            begin
                ctl.load_read = 1'b1;
                state_next    = fidi_pkg::ST_IDLE;
            end
            fidi_pkg::ST_RUN_INIT:
            begin
                ctl.run_init = 1'b1;
                state_next   = fidi_pkg::ST_BLOCK;
            end
            fidi_pkg::ST_BLOCK:
            begin
                if (stat.blk_ok)
                begin
                    ctl.map_rd = 1'b1;
                    state_next = fidi_pkg::ST_FETCH0;
                end
                else
                begin
                    state_next = fidi_pkg::ST_DONE;
                end
            end
            fidi_pkg::ST_FETCH0:
            begin
                ctl.fetch   = 1'b1;
                ctl.fetch_k = 2'd0;
                state_next  = fidi_pkg::ST_FETCH1;
            end
            fidi_pkg::ST_FETCH1:
            begin
                ctl.fetch   = 1'b1;
                ctl.fetch_k = 2'd1;
                state_next  = fidi_pkg::ST_FETCH2;
            end
            fidi_pkg::ST_FETCH2:
            begin
                ctl.fetch   = 1'b1;
                ctl.fetch_k = 2'd2;
                state_next  = fidi_pkg::ST_FETCH3;
            end
            fidi_pkg::ST_FETCH3:
            begin
                ctl.fetch   = 1'b1;
                ctl.fetch_k = 2'd3;
                state_next  = fidi_pkg::ST_ACC;
            end
            fidi_pkg::ST_ACC:
            begin
                // last cell pixel lands in the sum
                state_next = fidi_pkg::ST_MUL;
            end
            fidi_pkg::ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = fidi_pkg::ST_STORE;
            end
            fidi_pkg::ST_STORE:
            begin
                ctl.store = 1'b1;
                if (!stat.pix_last)
                begin
                    ctl.step_pix = 1'b1;
                    state_next   = fidi_pkg::ST_FETCH0;
                end
                else if (stat.blk_last)
                begin
                    state_next = fidi_pkg::ST_DONE;
                end
                else
                begin
                    ctl.step_blk = 1'b1;
                    state_next   = fidi_pkg::ST_BLOCK;
                end
            end
            fidi_pkg::ST_DONE:
            begin
                ctl.load_done = 1'b1;
                state_next    = fidi_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fidi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/fidi_datapath.sv
// buffers, mapping table, address generation and pixel arithmetic
module fidi_datapath #(
    parameter int IMAGE_SIDE = 256,
    parameter int MAX_BLOCKS = 16384,
    parameter int SCALE_BASE = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fidi_pkg::ctrl_cmd_t ctl,
    output fidi_pkg::dp_stat_t  stat,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_data,
    input  logic [1:0]          cmd,
    input  logic [15:0]         item_index,
    input  logic [7:0]          pixel_value,
    input  logic [7:0]          domain_x,
    input  logic [7:0]          domain_y,
    input  logic signed [15:0]  scale,
    input  logic signed [15:0]  bias,
    input  logic [2:0]          orientation,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [7:0]          read_value,
    output logic [1:0]          cmd_echo
);

    localparam int SIDE_W = $clog2(IMAGE_SIDE);
    localparam int PIX_AW = 2 * SIDE_W;
    localparam int NPIX   = IMAGE_SIDE * IMAGE_SIDE;
    localparam int MAP_AW = $clog2(MAX_BLOCKS);
    localparam int BI_W   = 2 * SIDE_W;
    localparam int SB_LOG = $clog2(SCALE_BASE);
    localparam int OFS_W  = fidi_pkg::OFS_W;
    localparam int MAP_W  = $bits(fidi_pkg::map_entry_t);
    localparam int PROD_W = 25;
    localparam int T_W    = 27;
    localparam int TB_W   = T_W + 1;
    localparam logic signed [T_W-1:0] HALF = T_W'(SCALE_BASE / 2);
    localparam logic signed [T_W-1:0] RND  = T_W'(SCALE_BASE - 1);

    // configuration and run state
    logic [2:0]        lg_cfg_reg;
    logic [2:0]        lg_reg;
    logic              cur_sel_reg;
    logic [SIDE_W-1:0] br_reg;
    logic [SIDE_W-1:0] bc_reg;
    logic [BI_W-1:0]   bi_reg;
    logic [OFS_W-1:0]  r_reg;
    logic [OFS_W-1:0]  c_reg;

    logic [SIDE_W-1:0] bps_m1;
    logic [OFS_W-1:0]  bs_m1;
    logic              no_blocks;
    logic [2:0]        lg_eff;

    // pixel pipeline
    logic                     acc_pend_reg;
    logic [9:0]               sum_reg;
    logic [9:0]               sum_next;
    logic                     rsel_reg;
    logic                     rd_ok_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [7:0]               avg;

    // output word
    logic       out_valid_reg;
    logic [7:0] read_value_reg;
    logic [1:0] cmd_echo_reg;

    // memories
    logic              img_we_a;
    logic              img_we_b;
    logic              img_re;
    logic [PIX_AW-1:0] img_waddr;
    logic [PIX_AW-1:0] img_raddr;
    logic [7:0]        img_wdata;
    logic [7:0]        rdata_a;
    logic [7:0]        rdata_b;
    logic [7:0]        pix_rdata;

    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr;
    logic [MAP_W-1:0]     map_wdata;
    logic [MAP_W-1:0]     map_rdata;
    fidi_pkg::map_entry_t map_in;
    fidi_pkg::map_entry_t map_q;

    logic              wpix;
    logic              wmap;
    logic              rpix;
    logic              pix_in_range;
    logic              wr_cmd;
    logic [2*OFS_W-1:0] ofs;
    logic [SIDE_W-1:0] src_y;
    logic [SIDE_W-1:0] src_x;
    logic [SIDE_W-1:0] dst_y;
    logic [SIDE_W-1:0] dst_x;
    logic [7:0]        result_pix;

    logic signed [T_W-1:0]  tsum;
    logic signed [T_W-1:0]  tadj;
    logic signed [T_W-1:0]  tq;
    logic signed [TB_W-1:0] tb;

    assign lg_eff = (lg_cfg_reg < fidi_pkg::LG_MIN) ? fidi_pkg::LG_MIN :
                    (lg_cfg_reg > fidi_pkg::LG_MAX) ? fidi_pkg::LG_MAX : lg_cfg_reg;

    assign no_blocks = (IMAGE_SIDE >> lg_reg) == 0;
    assign bps_m1    = SIDE_W'((IMAGE_SIDE >> lg_reg) - 1);
    assign bs_m1     = OFS_W'((6'd1 << lg_reg) - 6'd1);

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.blk_ok   = !no_blocks && (32'(bi_reg) < MAX_BLOCKS);
    assign stat.pix_last = (r_reg == bs_m1) && (c_reg == bs_m1);
    assign stat.blk_last = (br_reg == bps_m1) && (bc_reg == bps_m1);

    // command decode at accept
    assign pix_in_range = 32'(item_index) < NPIX;
    assign wr_cmd = (cmd == fidi_pkg::CMD_WRITE_PIX) || (cmd == fidi_pkg::CMD_WRITE_MAP);
    assign wpix   = ctl.accept && (cmd == fidi_pkg::CMD_WRITE_PIX) && pix_in_range;
    assign wmap   = ctl.accept && (cmd == fidi_pkg::CMD_WRITE_MAP)
                    && (32'(item_index) < MAX_BLOCKS);
    assign rpix   = ctl.accept && (cmd == fidi_pkg::CMD_READ);

    // source cell address, wraps at the image edge
    assign map_q = fidi_pkg::map_entry_t'(map_rdata);
    assign ofs   = fidi_pkg::cell_offset(map_q.orientation, r_reg, c_reg, bs_m1);
    assign src_y = SIDE_W'(map_q.domain_y) + SIDE_W'({ofs[2*OFS_W-1:OFS_W], 1'b0})
                   + SIDE_W'(ctl.fetch_k[1]);
    assign src_x = SIDE_W'(map_q.domain_x) + SIDE_W'({ofs[OFS_W-1:0], 1'b0})
                   + SIDE_W'(ctl.fetch_k[0]);

    assign dst_y = (br_reg << lg_reg) | SIDE_W'(r_reg);
    assign dst_x = (bc_reg << lg_reg) | SIDE_W'(c_reg);

    // writes always go to the current buffer
    assign img_waddr = ctl.store ? {dst_y, dst_x} : PIX_AW'(item_index);
    assign img_wdata = ctl.store ? result_pix : pixel_value;
    assign img_we_a  = (wpix || ctl.store) && !cur_sel_reg;
    assign img_we_b  = (wpix || ctl.store) && cur_sel_reg;
    assign img_re    = rpix || ctl.fetch;
    assign img_raddr = ctl.fetch ? {src_y, src_x} : PIX_AW'(item_index);
    assign pix_rdata = rsel_reg ? rdata_b : rdata_a;

    assign map_in.orientation = orientation;
    assign map_in.bias        = bias;
    assign map_in.scale       = scale;
    assign map_in.domain_y    = domain_y;
    assign map_in.domain_x    = domain_x;
    assign map_we    = wmap;
    assign map_waddr = MAP_AW'(item_index);
    assign map_wdata = map_in;

    fidi_ram #(.WIDTH(8), .DEPTH(NPIX)) u_image_a (
        .clk   (clk),
        .we    (img_we_a),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .re    (img_re),
        .raddr (img_raddr),
        .rdata (rdata_a)
    );

    fidi_ram #(.WIDTH(8), .DEPTH(NPIX)) u_image_b (
        .clk   (clk),
        .we    (img_we_b),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .re    (img_re),
        .raddr (img_raddr),
        .rdata (rdata_b)
    );

    fidi_ram #(.WIDTH(MAP_W), .DEPTH(MAX_BLOCKS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (ctl.map_rd),
        .raddr (MAP_AW'(bi_reg)),
        .rdata (map_rdata)
    );

    // rounded average, scale (half added, then truncated toward zero), bias, clamp
    assign avg  = 8'((sum_reg + 10'd2) >> 2);
    assign tsum = T_W'(prod_reg) + HALF;
    assign tadj = tsum[T_W-1] ? (tsum + RND) : tsum;
    assign tq   = tadj >>> SB_LOG;
    assign tb   = TB_W'(tq) + TB_W'(map_q.bias);
    assign result_pix = tb[TB_W-1] ? 8'd0 :
                        (tb > TB_W'(255)) ? 8'd255 : tb[7:0];

    assign sum_next = acc_pend_reg ? (sum_reg + 10'(pix_rdata)) :
                      (ctl.fetch && (ctl.fetch_k == 2'd0)) ? 10'd0 : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_cfg_reg    <= 3'd3;
            lg_reg        <= 3'd3;
            cur_sel_reg   <= 1'b0;
            br_reg        <= '0;
            bc_reg        <= '0;
            bi_reg        <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                lg_cfg_reg <= cfg_data;
            end
            acc_pend_reg <= ctl.fetch;
            if (ctl.run_init)
            begin
                lg_reg      <= lg_eff;
                cur_sel_reg <= !cur_sel_reg;
                br_reg      <= '0;
                bc_reg      <= '0;
                bi_reg      <= '0;
                r_reg       <= '0;
                c_reg       <= '0;
            end
            else if (ctl.step_pix)
            begin
                if (c_reg == bs_m1)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            else if (ctl.step_blk)
            begin
                r_reg  <= '0;
                c_reg  <= '0;
                bi_reg <= bi_reg + 1'b1;
                if (bc_reg == bps_m1)
                begin
                    bc_reg <= '0;
                    br_reg <= br_reg + 1'b1;
                end
                else
                begin
                    bc_reg <= bc_reg + 1'b1;
                end
            end
            if (ctl.load_read || ctl.load_done || (ctl.accept && wr_cmd))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (ctl.fetch)
        begin
            rsel_reg <= !cur_sel_reg;
        end
        else if (rpix)
        begin
            rsel_reg  <= cur_sel_reg;
            rd_ok_reg <= pix_in_range;
        end
        if (ctl.mul)
        begin
            prod_reg <= $signed({1'b0, avg}) * map_q.scale;
        end
        if (ctl.accept && wr_cmd)
        begin
            read_value_reg <= 8'd0;
            cmd_echo_reg   <= cmd;
        end
        else if (ctl.load_read)
        begin
            read_value_reg <= rd_ok_reg ? pix_rdata : 8'd0;
            cmd_echo_reg   <= fidi_pkg::CMD_READ;
        end
        else if (ctl.load_done)
        begin
            read_value_reg <= 8'd0;
            cmd_echo_reg   <= fidi_pkg::CMD_RUN;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign cmd_echo   = cmd_echo_reg;

endmodule

>>> rtl/core/fractal_image_decode_iteration_core.sv
// top level of the fractal image decode iteration core
// Pixel writes, mapping writes and pixel reads take one command each and give one
// result word: writes post their result in the cycle after acceptance, reads after
// the ST_READ state, once the buffer read has returned. A run command swaps the two
// image buffers and rebuilds the current image from the other one. Each pixel reads
// the four pixels of its source cell through the single read port of the source
// buffer, then drains the read, passes the multiplier and is written back. IMAGE_SIDE
// and SCALE_BASE must be powers of two. No new command is taken while a command is
// in progress.
`include "fractal_image_decode_iteration_core_assert.svh"

module fractal_image_decode_iteration_core #(
    parameter int IMAGE_SIDE = 256,
    parameter int MAX_BLOCKS = 16384,
    parameter int SCALE_BASE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [15:0]        item_index,
    input  logic [7:0]         pixel_value,
    input  logic [7:0]         domain_x,
    input  logic [7:0]         domain_y,
    input  logic signed [15:0] scale,
    input  logic signed [15:0] bias,
    input  logic [2:0]         orientation,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         read_value,
    output logic [1:0]         cmd_echo
);

    fidi_pkg::ctrl_cmd_t ctl;
    fidi_pkg::dp_stat_t  stat;
    logic                wr_accept;
    logic                rd_accept;

    assign cfg_ready = 1'b1;

    fidi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .stat     (stat),
        .in_stall (in_stall),
        .ctl      (ctl)
    );

    fidi_datapath #(
        .IMAGE_SIDE (IMAGE_SIDE),
        .MAX_BLOCKS (MAX_BLOCKS),
        .SCALE_BASE (SCALE_BASE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .item_index  (item_index),
        .pixel_value (pixel_value),
        .domain_x    (domain_x),
        .domain_y    (domain_y),
        .scale       (scale),
        .bias        (bias),
        .orientation (orientation),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .read_value  (read_value),
        .cmd_echo    (cmd_echo)
    );

    assign wr_accept = in_valid && !in_stall
                       && (cmd == fidi_pkg::CMD_WRITE_PIX || cmd == fidi_pkg::CMD_WRITE_MAP);
    assign rd_accept = in_valid && !in_stall && (cmd == fidi_pkg::CMD_READ);

    // a write command posts its word right away
    `FIDI_ASSERT_NEXT(a_write_posts, clk, rst_n, wr_accept, out_valid && cmd_echo == $past(cmd))
    // a read posts its word once the buffer read returns
    `FIDI_ASSERT_IMPL(a_read_posts, clk, rst_n, rd_accept, ##2 (out_valid && cmd_echo == 2'd3))
    // only reads carry a pixel value
    `FIDI_ASSERT_IMPL(a_value_only_read, clk, rst_n, out_valid && read_value != 8'd0, cmd_echo == fidi_pkg::CMD_READ)

endmodule
